// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the bitmap block allocator
// Map geometry, request and status codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bba_pkg;

    // Map geometry (WORD_BITS must be a power of two)
    localparam int NUM_BLOCKS = 1024;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WIDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int NUM_W      = $clog2(NUM_BLOCKS + 1);

    // Item field widths
    localparam int REQ_W   = 2;
    localparam int BLK_W   = 12;
    localparam int STAT_W  = 2;
    localparam int GRANT_W = 10;
    localparam int RSV_W   = 11;

    localparam logic [RSV_W-1:0] RSV_RESET = RSV_W'(4);

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [WIDX_W-1:0]    t_widx;
    typedef logic [BIT_W-1:0]     t_bidx;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FORMAT = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_WRITE
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic capture;   // latch a new item
        logic find;      // select and read the target word
        logic commit;    // write back the word and load the result
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic out_full;  // result register still holds an item
    } t_dp_sts;

    // Bits of word w that stand for real blocks
    function automatic t_word word_valid(input int w);
        int first;
        int left;
        first = w * WORD_BITS;
        left  = NUM_BLOCKS - first;
        if (first >= NUM_BLOCKS) begin
            return '0;
        end else if (left >= WORD_BITS) begin
            return '1;
        end else begin
            return ~(t_word'('1) << left);
        end
    endfunction

endpackage

// ===== rtl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl: request sequencer
// Takes one item at a time through a find step and a write-back step;
// a new item is taken in the write-back cycle when the result register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  bba_pkg::t_dp_sts i_sts,
    output bba_pkg::t_dp_cmd o_cmd
);
    import bba_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (!i_sts.out_full) begin
                    n_state = i_in_valid ? S_FIND : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
            end
            S_WRITE: begin
                if (!i_sts.out_full) begin
                    o_cmd.commit  = 1'b1;
                    o_in_stall    = 1'b0;
                    o_cmd.capture = i_in_valid;
                end
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/bba_dp.sv =====
// ----------------------------------------------------------------------------
// bba_dp: free map datapath
// Holds the free map with per-word nonempty flags, the reserve register,
// the word pick, the bit pick, the write-back and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [bba_pkg::RSV_W-1:0]     i_cfg_data,
    // request
    input  logic [bba_pkg::REQ_W-1:0]     i_req_type,
    input  logic [bba_pkg::BLK_W-1:0]     i_block_index,
    // result
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bba_pkg::STAT_W-1:0]    o_status,
    output logic [bba_pkg::GRANT_W-1:0]   o_granted_block,
    // control
    input  bba_pkg::t_dp_cmd              i_cmd,
    output bba_pkg::t_dp_sts              o_sts
);
    import bba_pkg::*;

    t_word                r_map [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_nonempty;
    logic [RSV_W-1:0]     r_reserved;

    // latched request
    logic [REQ_W-1:0]     r_req;
    t_widx                r_req_word;
    t_bidx                r_req_bit;
    logic                 r_req_in_range;

    // find stage results
    t_widx                r_word;
    t_word                r_rd_word;
    logic                 r_found;

    // result register
    logic                 r_out_valid;
    logic [STAT_W-1:0]    r_status;
    logic [GRANT_W-1:0]   r_grant;
    logic [STAT_W-1:0]    n_status;
    logic [GRANT_W-1:0]   n_grant;

    t_widx                pick_word;
    logic                 any_free;
    t_widx                sel_word;
    t_bidx                pick_bit;
    t_word                new_word;
    logic [NUM_W-1:0]     rsv_sat;
    t_word                fmt_word [MAP_WORDS];

    // Reserve register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved <= RSV_RESET;
        end else if (i_cfg_we) begin
            r_reserved <= i_cfg_data;
        end
    end

    // Request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req          <= i_req_type;
            r_req_word     <= t_widx'(32'(i_block_index) >> BIT_W);
            r_req_bit      <= i_block_index[BIT_W-1:0];
            r_req_in_range <= (32'(i_block_index) < 32'(NUM_BLOCKS));
        end
    end

    // Lowest word with a free block
    always_comb begin
        pick_word = '0;
        any_free  = |r_nonempty;
        for (int w = MAP_WORDS - 1; w >= 0; w--) begin
            if (r_nonempty[w]) begin
                pick_word = t_widx'(w);
            end
        end
    end

    assign sel_word = (r_req == REQ_ALLOC) ? pick_word : r_req_word;

    // Find stage: read the target word
    always_ff @(posedge i_clk) begin
        if (i_cmd.find) begin
            r_word    <= sel_word;
            r_rd_word <= r_map[sel_word];
            r_found   <= any_free;
        end
    end

    // Lowest free bit of the word read
    always_comb begin
        pick_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (r_rd_word[b]) begin
                pick_bit = t_bidx'(b);
            end
        end
    end

    // Word after the update
    always_comb begin
        if (r_req == REQ_ALLOC) begin
            new_word = r_rd_word & ~(t_word'(1) << pick_bit);
        end else begin
            new_word = r_rd_word | (t_word'(1) << r_req_bit);
        end
    end

    // Format image: blocks below the saturated reserve are used
    assign rsv_sat = (32'(r_reserved) > 32'(NUM_BLOCKS)) ? NUM_W'(NUM_BLOCKS)
                                                          : NUM_W'(r_reserved);

    always_comb begin
        for (int w = 0; w < MAP_WORDS; w++) begin
            if (32'(rsv_sat) >= 32'(w * WORD_BITS + WORD_BITS)) begin
                fmt_word[w] = '0;
            end else if (32'(rsv_sat) <= 32'(w * WORD_BITS)) begin
                fmt_word[w] = word_valid(w);
            end else begin
                fmt_word[w] = word_valid(w)
                    & (t_word'('1) << BIT_W'(32'(rsv_sat) - 32'(w * WORD_BITS)));
            end
        end
    end

    // Free map and nonempty flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < MAP_WORDS; w++) begin
                r_map[w]      <= word_valid(w);
                r_nonempty[w] <= |word_valid(w);
            end
        end else if (i_cmd.commit) begin
            unique case (r_req)
                REQ_ALLOC: begin
                    if (r_found) begin
                        r_map[r_word]      <= new_word;
                        r_nonempty[r_word] <= |new_word;
                    end
                end
                REQ_FREE: begin
                    if (r_req_in_range) begin
                        r_map[r_word]      <= new_word;
                        r_nonempty[r_word] <= 1'b1;
                    end
                end
                REQ_FORMAT: begin
                    for (int w = 0; w < MAP_WORDS; w++) begin
                        r_map[w]      <= fmt_word[w];
                        r_nonempty[w] <= |fmt_word[w];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload for the item in write-back
    always_comb begin
        n_status = ST_OK;
        n_grant  = '0;
        unique case (r_req)
            REQ_ALLOC: begin
                if (r_found) begin
                    n_grant = GRANT_W'({r_word, pick_bit});
                end else begin
                    n_status = ST_FULL;
                end
            end
            REQ_FREE: begin
                if (!r_req_in_range) begin
                    n_status = ST_RANGE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_grant  <= n_grant;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_granted_block = r_grant;
    assign o_sts.out_full  = r_out_valid;

endmodule

// ===== rtl/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator: first-fit bitmap block allocator
// Request channel in (allocate, free, format), one result item out per request.
//
// Usage:
//   Request items enter on i_in_valid / o_in_stall with i_req_type and
//   i_block_index; each gives one result item on o_out_valid / i_out_stall
//   with o_status and o_granted_block.
//   One configuration register, reserved_count, is written through
//   i_cfg_valid / o_cfg_ready / i_cfg_data; write it only while idle.
//   A taken request is latched; the find step then reads the target word
//   (for an allocate, per-word nonempty flags pick the lowest free word),
//   and the bit pick and write-back step loads the result register. A new
//   item is taken in the write-back step when the result register is free.
//   The result sits in an output register; the next item is taken while it
//   waits. If that register is still full at write-back, the block holds
//   there and stalls the request side until the receiver takes the result.
//   Reset (synchronous, active low) marks every block free, sets
//   reserved_count to 4 and empties the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_block_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bba_pkg::RSV_W-1:0]     i_cfg_data,
    // request items
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bba_pkg::REQ_W-1:0]     i_req_type,
    input  logic [bba_pkg::BLK_W-1:0]     i_block_index,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bba_pkg::STAT_W-1:0]    o_status,
    output logic [bba_pkg::GRANT_W-1:0]   o_granted_block
);
    import bba_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bba_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_block_index   (i_block_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_granted_block (o_granted_block),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

endmodule

// ===== rtl/bba_checker.sv =====
// ----------------------------------------------------------------------------
// bba_checker: port-level checks of the bitmap block allocator
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [bba_pkg::STAT_W-1:0]    o_status,
    input  logic [bba_pkg::GRANT_W-1:0]   o_granted_block
);
    import bba_pkg::*;

    // Held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_granted_block))
        else $error("result changed while stalled");

    // One item at a time: the find cycle never takes another item
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item taken during find step");

    // A failed request reports no block: its grant is zero
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_granted_block == '0)
        else $error("nonzero grant on failed request");

    // Status codes stay in their set
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == ST_OK || o_status == ST_FULL
                        || o_status == ST_RANGE)
        else $error("undefined status code");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_granted_block (o_granted_block)
);

// ===== tb/sv/tb_bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_bitmap_block_allocator: self-checking bench for the bitmap block allocator
// A queue of request items feeds a clocked driver. A free-map model predicts
// each result item as its request is taken. A clocked monitor checks every
// result item against the oldest prediction. Random gaps hit the requests,
// random stalls the results. reserved_count is rewritten between phases
// while the block is idle, at its extremes and at values in between.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bitmap_block_allocator;
    import bba_pkg::*;

    // request code with no meaning; the block must ignore it
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RAND_PER_PHASE = 175;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [BLK_W-1:0] idx;
    } t_request;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [GRANT_W-1:0] grant;
    } t_reply;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic [RSV_W-1:0]   cfg_data    = '0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic [REQ_W-1:0]   req_type    = REQ_ALLOC;
    logic [BLK_W-1:0]   block_index = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [STAT_W-1:0]  status;
    logic [GRANT_W-1:0] granted_block;

    // free-map model: set bit = free block
    t_word            free_map [MAP_WORDS];
    logic [RSV_W-1:0] rsv_model = RSV_RESET;

    t_request req_q[$];
    t_reply   reply_q[$];
    int       issued_cnt  = 0;   // requests taken (updated at the edge)
    int       checked_cnt = 0;   // results checked
    int       failures    = 0;
    int       gap_left    = 0;
    int       calm_left   = 0;
    int       stall_left  = 0;
    logic     stall_on    = 1'b0;

    bitmap_block_allocator dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_req_type      (req_type),
        .i_block_index   (block_index),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_status        (status),
        .o_granted_block (granted_block)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // everything used, then every block from n upward free
    function automatic void map_format(int n);
        int blk;
        foreach (free_map[w]) free_map[w] = '0;
        for (blk = n; blk < NUM_BLOCKS; blk++) begin
            free_map[blk / WORD_BITS][blk % WORD_BITS] = 1'b1;
        end
    endfunction

    // apply one request to the model and return the result it gives
    function automatic t_reply predict_reply(logic [REQ_W-1:0] req, logic [BLK_W-1:0] idx);
        t_reply rep;
        int     w;
        int     b;
        int     n;
        bit     found;
        rep.status = ST_OK;
        rep.grant  = '0;
        found      = 1'b0;
        case (req)
            REQ_ALLOC: begin
                for (w = 0; w < MAP_WORDS && !found; w++) begin
                    for (b = 0; b < WORD_BITS && !found; b++) begin
                        if (free_map[w][b] && (w * WORD_BITS + b) < NUM_BLOCKS) begin
                            found          = 1'b1;
                            free_map[w][b] = 1'b0;
                            rep.grant      = GRANT_W'(w * WORD_BITS + b);
                        end
                    end
                end
                if (!found) rep.status = ST_FULL;
            end
            REQ_FREE: begin
                if (idx < NUM_BLOCKS) begin
                    free_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
                end else begin
                    rep.status = ST_RANGE;
                end
            end
            REQ_FORMAT: begin
                n = (rsv_model > NUM_BLOCKS) ? NUM_BLOCKS : int'(rsv_model);
                map_format(n);
            end
            default: ;
        endcase
        return rep;
    endfunction

    // idle cycles after an item: mostly none or short, a few long, calm runs
    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic void push_req(logic [REQ_W-1:0] req, logic [BLK_W-1:0] idx);
        t_request item;
        item.req = req;
        item.idx = idx;
        req_q.push_back(item);
    endfunction

    // request driver: predicts each item as it is taken
    always @(posedge clk) begin : req_driver
        t_request nxt;
        logic     next_valid;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            next_valid = in_valid;
            if (in_valid && !in_stall) begin
                reply_q.push_back(predict_reply(req_type, block_index));
                issued_cnt <= issued_cnt + 1;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (req_q.size() > 0) begin
                    nxt         = req_q.pop_front();
                    req_type    <= nxt.req;
                    block_index <= nxt.idx;
                    next_valid  = 1'b1;
                    gap_left    = pick_gap();
                end
            end
            in_valid <= next_valid;
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge clk) begin : reply_monitor
        t_reply want;
        int     r;
        if (rst_n && out_valid && !out_stall) begin
            if (checked_cnt == issued_cnt) begin
                failures++;
                $display("%0t: result item with nothing expected (status %0d, block %0d)",
                         $time, status, granted_block);
            end else begin
                want = reply_q.pop_front();
                checked_cnt++;
                if (status !== want.status) begin
                    failures++;
                    $display("%0t: status expected %0d, actual %0d",
                             $time, want.status, status);
                end
                if (granted_block !== want.grant) begin
                    failures++;
                    $display("%0t: granted_block expected %0d, actual %0d",
                             $time, want.grant, granted_block);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
                stall_on   = 1'b0;
                stall_left = $urandom_range(40, 120);
            end else if (r < 70) begin
                stall_on   = 1'b0;
                stall_left = $urandom_range(0, 5);
            end else if (r < 93) begin
                stall_on   = 1'b1;
                stall_left = $urandom_range(0, 2);
            end else begin
                stall_on   = 1'b1;
                stall_left = $urandom_range(8, 40);
            end
        end
        out_stall <= stall_on;
    end

    task automatic write_reserve(input logic [RSV_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        rsv_model = value;
        cfg_valid <= 1'b0;
    endtask

    // sample at the falling edge so the clocked blocks have settled
    task automatic wait_idle();
        @(negedge clk);
        while (req_q.size() != 0 || in_valid || issued_cnt != checked_cnt) begin
            @(negedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    initial begin : stimulus
        logic [RSV_W-1:0] rsv_plan [8];
        int               hot;
        int               k;
        int               r;
        map_format(0);
        rsv_plan = '{11'd0, 11'd1024, 11'd1025, 11'd1000, 11'd2047, 11'd32, 11'd0, 11'd0};
        rsv_plan[6] = RSV_W'($urandom);
        rsv_plan[7] = RSV_W'($urandom_range(990, 1023));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // after reset the whole map is free, reserve at its reset value
        push_req(REQ_ALLOC, '0);
        push_req(REQ_ALLOC, '1);
        push_req(REQ_FREE, 12'd0);
        push_req(REQ_FREE, 12'd0);       // double free is harmless
        push_req(REQ_ALLOC, '0);
        push_req(REQ_FREE, 12'd1023);
        push_req(REQ_FREE, 12'd1024);    // first index out of range
        push_req(REQ_FREE, 12'd4095);
        push_req(REQ_UNUSED, 12'd4095);
        push_req(REQ_UNUSED, 12'd0);
        push_req(REQ_FORMAT, 12'd0);
        push_req(REQ_ALLOC, 12'd0);
        push_req(REQ_FREE, 12'd2);
        push_req(REQ_ALLOC, 12'd0);
        wait_idle();

        // oversize reserve saturates: format leaves the map full
        write_reserve(11'd2047);
        push_req(REQ_FORMAT, '1);
        push_req(REQ_ALLOC, 12'd0);
        push_req(REQ_FREE, 12'd1023);
        push_req(REQ_ALLOC, 12'd0);
        push_req(REQ_ALLOC, 12'd0);
        push_req(REQ_FREE, 12'd32);      // word boundary
        push_req(REQ_FREE, 12'd31);
        push_req(REQ_ALLOC, 12'd0);
        push_req(REQ_ALLOC, 12'd0);
        push_req(REQ_ALLOC, 12'd0);
        wait_idle();

        // random phases, one reserve setting each
        foreach (rsv_plan[p]) begin
            write_reserve(rsv_plan[p]);
            hot = (rsv_plan[p] > NUM_BLOCKS) ? NUM_BLOCKS : int'(rsv_plan[p]);
            hot = (hot + 64 > NUM_BLOCKS - 1) ? NUM_BLOCKS - 1 : hot + 64;
            if ($urandom_range(0, 9) < 8) push_req(REQ_FORMAT, BLK_W'($urandom));
            for (k = 0; k < RAND_PER_PHASE; k++) begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    push_req(REQ_ALLOC, BLK_W'($urandom));
                end else if (r < 72) begin
                    push_req(REQ_FREE, BLK_W'($urandom_range(0, hot)));
                end else if (r < 84) begin
                    push_req(REQ_FREE, BLK_W'($urandom_range(0, NUM_BLOCKS - 1)));
                end else if (r < 91) begin
                    push_req(REQ_FREE, BLK_W'($urandom_range(NUM_BLOCKS, 4095)));
                end else if (r < 96) begin
                    push_req(REQ_FORMAT, BLK_W'($urandom));
                end else begin
                    push_req(REQ_UNUSED, BLK_W'($urandom));
                end
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (failures == 0) begin
            $display("** bitmap_block_allocator: PASSED **");
        end else begin
            $display("** bitmap_block_allocator: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #10_000_000;
        $display("** bitmap_block_allocator: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bba_pkg.sv
rtl/bba_ctrl.sv
rtl/bba_dp.sv
rtl/bitmap_block_allocator.sv
rtl/bba_checker.sv
tb/sv/tb_bitmap_block_allocator.sv
